@@ sv/scsa_pkg.sv @@
// Shared types, constants and helpers for the size-class slab allocator.
`timescale 1ns / 1ps
package scsa_pkg;

    localparam int POOL_PAGES    = 64;
    localparam int PAGE_W        = 6;
    localparam int SIZE_CLASSES  = 7;
    localparam int SLOT_W        = 7;
    localparam int SLOTS_PER_PAGE = 128;

    localparam logic [PAGE_W:0] LIST_END = 7'(POOL_PAGES);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] request_bytes;
        logic [17:0] object_address;
    } req_t;

    typedef struct packed {
        logic [17:0] granted_address;
        logic [11:0] slot_bytes;
        logic [1:0]  status;
    } rsp_t;

    // Usable slots in a page of class c (slot 0 is bookkeeping).
    function automatic logic [6:0] slots_usable(input logic [2:0] c);
        logic [12:0] n;
        n = 13'd4096 >> (5 + c);
        return 7'(n - 13'd1);
    endfunction

    // Slot size in bytes of class c.
    function automatic logic [11:0] class_bytes(input logic [2:0] c);
        return 12'(12'd32 << c);
    endfunction

endpackage

@@ sv/scsa_slot_ram.sv @@
// Slot link memory: one free-stack link per slot of every page.
`timescale 1ns / 1ps
module scsa_slot_ram (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [scsa_pkg::PAGE_W+scsa_pkg::SLOT_W-1:0] waddr,
    input  logic [scsa_pkg::SLOT_W-1:0]            wdata,
    input  logic [scsa_pkg::PAGE_W+scsa_pkg::SLOT_W-1:0] raddr,
    output logic [scsa_pkg::SLOT_W-1:0]            rdata
);
    logic [scsa_pkg::SLOT_W-1:0] mem [scsa_pkg::POOL_PAGES*scsa_pkg::SLOTS_PER_PAGE];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/size_class_slab_allocator.sv @@
// Top level of the size-class slab allocator.
`timescale 1ns / 1ps
// Hoard-style slab allocator over 64 pages of 4096 bytes, seven size classes
// from 32 to 2048 bytes. One beat in, one result beat out. Items are handled
// one at a time by a sequencer around a slot-link memory and per-page tables
// with registered reads. The input stalls while an item is in work and while
// its result beat waits to be taken. An allocation walks its class list (up
// to 64 pages). When a fresh page is claimed, the sequencer picks the lowest
// unused page and builds the page's free stack one slot at a time (up to 127
// slots). A release walks the page's free stack to detect a double release,
// and then may walk the class list for each page returned to the pool. No
// clearing pass is needed after reset.
module size_class_slab_allocator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  scsa_pkg::req_t        in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output scsa_pkg::rsp_t        out_data,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata
);
    localparam int PW = scsa_pkg::PAGE_W;
    localparam int SW = scsa_pkg::SLOT_W;
    localparam int NP = scsa_pkg::POOL_PAGES;
    localparam int NC = scsa_pkg::SIZE_CLASSES;

    localparam logic [PW:0] LIST_END_C = scsa_pkg::LIST_END;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_FINDPG  = 5'd2;
    localparam logic [4:0] S_BUILD   = 5'd3;
    localparam logic [4:0] S_WALK_RD = 5'd4;
    localparam logic [4:0] S_WALK    = 5'd5;
    localparam logic [4:0] S_POP_RD  = 5'd6;
    localparam logic [4:0] S_POP     = 5'd7;
    localparam logic [4:0] S_REL_RD  = 5'd8;
    localparam logic [4:0] S_REL_CHK = 5'd9;
    localparam logic [4:0] S_REL_STK = 5'd10;
    localparam logic [4:0] S_REL_DO  = 5'd11;
    localparam logic [4:0] S_TRIM    = 5'd12;
    localparam logic [4:0] S_TRIM_RD = 5'd13;
    localparam logic [4:0] S_TRIM_CK = 5'd14;
    localparam logic [4:0] S_RESP    = 5'd15;

    // Page tables: flops with valid-by-use for in_use; others are small memories.
    logic [NP-1:0]  page_in_use_reg;
    logic [2:0]     page_class_mem [NP];
    logic [SW-1:0]  page_free_mem  [NP];
    logic [PW:0]    page_next_mem  [NP];
    logic [SW-1:0]  page_head_mem  [NP];

    logic [PW:0]    class_head_reg  [NC];
    logic [13:0]    class_free_reg  [NC];
    logic [6:0]     class_whole_reg [NC];
    logic [6:0]     threshold_reg;

    logic [4:0]     state_reg;
    scsa_pkg::req_t req_reg;
    scsa_pkg::rsp_t rsp_reg;
    logic           out_valid_reg;
    logic [2:0]     cls_reg;
    logic [6:0]     full_reg;
    logic [PW:0]    cur_reg;
    logic [PW:0]    prev_reg;
    logic [6:0]     steps_reg;
    logic [SW-1:0]  slot_reg;
    logic [SW-1:0]  scan_reg;
    logic [SW-1:0]  cnt_reg;

    // Page table read port (registered).
    logic [PW-1:0]  prd_addr;
    logic [2:0]     prd_class;
    logic [SW-1:0]  prd_free;
    logic [PW:0]    prd_next;
    logic [SW-1:0]  prd_head;

    // Page table write port.
    logic           pw_free_we, pw_next_we, pw_head_we, pw_class_we;
    logic [PW-1:0]  pw_addr;
    logic [SW-1:0]  pw_free, pw_head;
    logic [PW:0]    pw_next;
    logic [2:0]     pw_class;
    logic           pn2_we;
    logic [PW-1:0]  pn2_addr;
    logic [PW:0]    pn2_data;

    // Slot link memory.
    logic                 sl_we;
    logic [PW+SW-1:0]     sl_waddr, sl_raddr;
    logic [SW-1:0]        sl_wdata, sl_rdata;

    scsa_slot_ram u_slot_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    always_ff @(posedge clk)
    begin
        prd_class <= page_class_mem[prd_addr];
        prd_free  <= page_free_mem[prd_addr];
        prd_next  <= page_next_mem[prd_addr];
        prd_head  <= page_head_mem[prd_addr];
        if (pw_class_we) page_class_mem[pw_addr] <= pw_class;
        if (pw_free_we)  page_free_mem[pw_addr]  <= pw_free;
        if (pw_head_we)  page_head_mem[pw_addr]  <= pw_head;
        if (pw_next_we)  page_next_mem[pw_addr]  <= pw_next;
        else if (pn2_we) page_next_mem[pn2_addr] <= pn2_data;
    end

    // Lowest unused page.
    logic [PW-1:0] free_page;
    logic          free_found;
    always_comb
    begin
        free_page  = '0;
        free_found = 1'b0;
        for (int i = NP - 1; i >= 0; i--)
        begin
            if (!page_in_use_reg[i])
            begin
                free_page  = PW'(i);
                free_found = 1'b1;
            end
        end
    end

    // Request decode.
    logic [2:0] req_cls;
    logic       req_big;
    always_comb
    begin
        req_cls = 3'd6;
        for (int k = 5; k >= 0; k--)
        begin
            if ({4'd0, req_reg.request_bytes} <= (20'd32 << k))
            begin
                req_cls = 3'(k);
            end
        end
        req_big = req_reg.request_bytes > 16'd2048;
    end

    logic [PW-1:0] rel_page;
    logic [11:0]   rel_off;
    logic [SW-1:0] rel_slot;
    logic [11:0]   rel_mask;
    assign rel_page = req_reg.object_address[PW+11:12];
    assign rel_off  = req_reg.object_address[11:0];
    assign rel_mask = 12'((13'd1 << (5 + prd_class)) - 13'd1);
    assign rel_slot = SW'(rel_off >> (5 + prd_class));

    logic [PW-1:0] cur_pg;
    assign cur_pg = cur_reg[PW-1:0];

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            page_in_use_reg <= '0;
            threshold_reg   <= 7'd2;
            req_reg         <= '0;
            rsp_reg         <= '0;
            cls_reg         <= '0;
            full_reg        <= '0;
            cur_reg         <= '0;
            prev_reg        <= '0;
            steps_reg       <= '0;
            slot_reg        <= '0;
            scan_reg        <= '0;
            cnt_reg         <= '0;
            for (int c = 0; c < NC; c++)
            begin
                class_head_reg[c]  <= LIST_END_C;
                class_free_reg[c]  <= '0;
                class_whole_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        req_reg   <= in_data;
                        rsp_reg   <= '0;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    steps_reg <= '0;
                    if (req_reg.action == scsa_pkg::ACT_ALLOC)
                    begin
                        cls_reg  <= req_cls;
                        full_reg <= scsa_pkg::slots_usable(req_cls);
                        if (req_big)
                        begin
                            rsp_reg.status <= scsa_pkg::ST_TOO_LARGE;
                            state_reg <= S_RESP;
                        end
                        else if (class_free_reg[req_cls] == '0)
                        begin
                            state_reg <= S_FINDPG;
                        end
                        else
                        begin
                            cur_reg   <= class_head_reg[req_cls];
                            state_reg <= S_WALK_RD;
                        end
                    end
                    else if (!page_in_use_reg[rel_page])
                    begin
                        rsp_reg.status <= scsa_pkg::ST_BAD_ADDR;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        cur_reg   <= {1'b0, rel_page};
                        state_reg <= S_REL_RD;
                    end
                end
                S_FINDPG:
                begin
                    if (!free_found)
                    begin
                        rsp_reg.status <= scsa_pkg::ST_EXHAUSTED;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        cur_reg  <= {1'b0, free_page};
                        page_in_use_reg[free_page] <= 1'b1;
                        class_head_reg[cls_reg]  <= {1'b0, free_page};
                        class_whole_reg[cls_reg] <= class_whole_reg[cls_reg] + 7'd1;
                        class_free_reg[cls_reg]  <= class_free_reg[cls_reg]
                                                    + 14'(full_reg);
                        prev_reg  <= class_head_reg[cls_reg];
                        scan_reg  <= 7'd1;
                        state_reg <= S_BUILD;
                    end
                end
                S_BUILD:
                begin
                    // Link slot n to n-1, one slot a cycle.
                    if (scan_reg == full_reg)
                    begin
                        state_reg <= S_WALK_RD;
                    end
                    scan_reg <= scan_reg + 7'd1;
                end
                S_WALK_RD:
                begin
                    if (cur_reg[PW] || steps_reg == 7'(NP))
                    begin
                        rsp_reg.status <= scsa_pkg::ST_EXHAUSTED;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (prd_free == '0)
                    begin
                        cur_reg   <= prd_next;
                        steps_reg <= steps_reg + 7'd1;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        slot_reg <= prd_head;
                        cnt_reg  <= prd_free;
                        if (prd_free == full_reg)
                        begin
                            class_whole_reg[cls_reg] <= class_whole_reg[cls_reg] - 7'd1;
                        end
                        state_reg <= S_POP_RD;
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    class_free_reg[cls_reg] <= class_free_reg[cls_reg] - 14'd1;
                    rsp_reg.granted_address <= 18'({cur_pg, 12'd0})
                        + 18'(({11'd0, slot_reg}) << (5 + cls_reg));
                    rsp_reg.slot_bytes <= scsa_pkg::class_bytes(cls_reg);
                    rsp_reg.status     <= scsa_pkg::ST_OK;
                    state_reg <= S_RESP;
                end
                S_REL_RD:
                begin
                    state_reg <= S_REL_CHK;
                end
                S_REL_CHK:
                begin
                    cls_reg  <= prd_class;
                    full_reg <= scsa_pkg::slots_usable(prd_class);
                    slot_reg <= rel_slot;
                    cnt_reg  <= '0;
                    scan_reg <= prd_head;
                    if (prd_class >= 3'(NC) || (rel_off & rel_mask) != '0
                        || rel_slot == '0
                        || rel_slot > scsa_pkg::slots_usable(prd_class)
                        || prd_free >= scsa_pkg::slots_usable(prd_class))
                    begin
                        rsp_reg.status <= scsa_pkg::ST_BAD_ADDR;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_REL_STK;
                    end
                end
                S_REL_STK:
                begin
                    // Walk the free stack: each link read waits for the registered slot memory output.
                    if (cnt_reg == prd_free)
                    begin
                        state_reg <= S_REL_DO;
                    end
                    else if (scan_reg == slot_reg)
                    begin
                        rsp_reg.status <= scsa_pkg::ST_BAD_ADDR;
                        state_reg <= S_RESP;
                    end
                    else if (steps_reg[0])
                    begin
                        scan_reg  <= sl_rdata;
                        cnt_reg   <= cnt_reg + 7'd1;
                        steps_reg <= '0;
                    end
                    else
                    begin
                        steps_reg <= 7'd1;
                    end
                end
                S_REL_DO:
                begin
                    if (prd_free == full_reg - 7'd1)
                    begin
                        class_whole_reg[cls_reg] <= class_whole_reg[cls_reg] + 7'd1;
                    end
                    class_free_reg[cls_reg] <= class_free_reg[cls_reg] + 14'd1;
                    rsp_reg.slot_bytes <= scsa_pkg::class_bytes(cls_reg);
                    rsp_reg.status     <= scsa_pkg::ST_OK;
                    state_reg <= S_TRIM;
                end
                S_TRIM:
                begin
                    if (class_whole_reg[cls_reg] > threshold_reg)
                    begin
                        cur_reg   <= class_head_reg[cls_reg];
                        prev_reg  <= LIST_END_C;
                        steps_reg <= '0;
                        state_reg <= S_TRIM_RD;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_TRIM_RD:
                begin
                    if (cur_reg[PW] || steps_reg == 7'(NP))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_TRIM_CK;
                    end
                end
                S_TRIM_CK:
                begin
                    if (prd_free != full_reg)
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= prd_next;
                        steps_reg <= steps_reg + 7'd1;
                        state_reg <= S_TRIM_RD;
                    end
                    else
                    begin
                        if (prev_reg[PW])
                        begin
                            class_head_reg[cls_reg] <= prd_next;
                        end
                        page_in_use_reg[cur_pg] <= 1'b0;
                        class_free_reg[cls_reg] <= class_free_reg[cls_reg]
                                                   - 14'(full_reg);
                        class_whole_reg[cls_reg] <= class_whole_reg[cls_reg] - 7'd1;
                        state_reg <= S_TRIM;
                    end
                end
                S_RESP:
                begin
                    // Output is empty here: the input stays stalled until it drains.
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Memory port steering.
    always_comb
    begin
        prd_addr    = cur_pg;
        pw_addr     = cur_pg;
        pw_class_we = 1'b0;
        pw_free_we  = 1'b0;
        pw_head_we  = 1'b0;
        pw_next_we  = 1'b0;
        pw_class    = cls_reg;
        pw_free     = '0;
        pw_head     = '0;
        pw_next     = prev_reg;
        pn2_we      = 1'b0;
        pn2_addr    = prev_reg[PW-1:0];
        pn2_data    = prd_next;
        sl_we       = 1'b0;
        sl_waddr    = {cur_pg, scan_reg};
        sl_wdata    = SW'(scan_reg - 7'd1);
        sl_raddr    = {cur_pg, slot_reg};
        unique case (state_reg)
            S_DECODE:
            begin
                prd_addr = rel_page;
            end
            S_FINDPG:
            begin
                pw_addr     = free_page;
                pw_class_we = free_found;
                pw_free_we  = free_found;
                pw_head_we  = free_found;
                pw_next_we  = free_found;
                pw_free     = full_reg;
                pw_head     = full_reg;
                pw_next     = class_head_reg[cls_reg];
            end
            S_BUILD:
            begin
                sl_we = 1'b1;
            end
            S_POP:
            begin
                pw_free_we = 1'b1;
                pw_head_we = 1'b1;
                pw_free    = cnt_reg - 7'd1;
                pw_head    = sl_rdata;
            end
            S_REL_STK:
            begin
                sl_raddr = {cur_pg, scan_reg};
            end
            S_REL_DO:
            begin
                sl_we      = 1'b1;
                sl_waddr   = {cur_pg, slot_reg};
                sl_wdata   = prd_head;
                pw_free_we = 1'b1;
                pw_head_we = 1'b1;
                pw_free    = prd_free + 7'd1;
                pw_head    = slot_reg;
            end
            S_TRIM_CK:
            begin
                pw_free_we = (prd_free == full_reg);
                pw_free    = '0;
                pn2_we     = (prd_free == full_reg) && !prev_reg[PW];
            end
            default:
            begin
            end
        endcase
    end

    // Hold the input while busy or while a result beat waits.
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // Checks.
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted beat did not start decode");
    a_ok_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == scsa_pkg::ST_OK) |-> (out_data.slot_bytes != '0))
        else $error("ok result without slot size");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != scsa_pkg::ST_OK)
        |-> (out_data.granted_address == '0 && out_data.slot_bytes == '0))
        else $error("error result carries payload");
endmodule
